>>> hw/rtl/link_target_unescape_defines.svh
// Assertion macros for the link target unescaper.
`ifndef LINK_TARGET_UNESCAPE_DEFINES_SVH
`define LINK_TARGET_UNESCAPE_DEFINES_SVH

`ifndef ASSERT_OFF

`define LTU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("link_target_unescape assertion failed");

`define LTU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("link_target_unescape assertion failed");

`else

`define LTU_ASSERT(lbl, clk, rst_n, prop)

`define LTU_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/ltu_pkg.sv
// Types, constants and character classes for the link target unescaper.
package ltu_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_PCT     = 2'd1,
        MODE_PCT_HEX = 2'd2,
        MODE_BSL     = 2'd3
    } t_mode;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] BSL_CHAR = 8'h5C;
    localparam int unsigned MaxOut = 3;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        t_mode           mode;
        logic [7:0]      held;
    } t_dec;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
    endfunction

endpackage

>>> hw/rtl/ltu_decode.sv
// Combinational decode of one raw byte against the held escape state.
module ltu_decode (
    input  ltu_pkg::t_mode i_mode,
    input  logic [7:0]     i_held,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output ltu_pkg::t_dec  o_dec
);
    import ltu_pkg::*;

    logic [7:0] v_b [4];
    logic [2:0] v_n;
    t_mode      v_mode;
    logic [7:0] v_held;
    logic       v_plain;

    always_comb begin
        v_b     = '{default: 8'h00};
        v_n     = 3'd0;
        v_mode  = i_mode;
        v_held  = i_held;
        v_plain = 1'b0;

        case (i_mode)
            MODE_PCT: begin
                if (is_hex(i_byte)) begin
                    v_held = i_byte;
                    v_mode = MODE_PCT_HEX;
                end else begin
                    v_b[v_n[1:0]] = PCT_CHAR;
                    v_n = v_n + 3'd1;
                    v_plain = 1'b1;
                end
            end
            MODE_PCT_HEX: begin
                if (is_hex(i_byte)) begin
                    v_b[v_n[1:0]] = {hex_value(i_held), hex_value(i_byte)};
                    v_n = v_n + 3'd1;
                    v_mode = MODE_PLAIN;
                end else begin
                    v_b[v_n[1:0]] = PCT_CHAR;
                    v_n = v_n + 3'd1;
                    v_b[v_n[1:0]] = i_held;
                    v_n = v_n + 3'd1;
                    v_plain = 1'b1;
                end
            end
            MODE_BSL: begin
                if (is_punct(i_byte)) begin
                    v_b[v_n[1:0]] = i_byte;
                    v_n = v_n + 3'd1;
                    v_mode = MODE_PLAIN;
                end else begin
                    v_b[v_n[1:0]] = BSL_CHAR;
                    v_n = v_n + 3'd1;
                    v_plain = 1'b1;
                end
            end
            default: begin
                v_plain = 1'b1;
            end
        endcase

        if (v_plain) begin
            if (i_byte == PCT_CHAR) begin
                v_mode = MODE_PCT;
            end else if (i_byte == BSL_CHAR) begin
                v_mode = MODE_BSL;
            end else begin
                v_mode = MODE_PLAIN;
                v_b[v_n[1:0]] = i_byte;
                v_n = v_n + 3'd1;
            end
        end

        if (i_last) begin
            case (v_mode)
                MODE_PCT: begin
                    v_b[v_n[1:0]] = PCT_CHAR;
                    v_n = v_n + 3'd1;
                end
                MODE_PCT_HEX: begin
                    v_b[v_n[1:0]] = PCT_CHAR;
                    v_n = v_n + 3'd1;
                    v_b[v_n[1:0]] = v_held;
                    v_n = v_n + 3'd1;
                end
                MODE_BSL: begin
                    v_b[v_n[1:0]] = BSL_CHAR;
                    v_n = v_n + 3'd1;
                end
                default: begin
                end
            endcase
            v_mode = MODE_PLAIN;
        end
    end

    // anything past the third word is dropped
    always_comb begin
        o_dec.bytes[0] = v_b[0];
        o_dec.bytes[1] = v_b[1];
        o_dec.bytes[2] = v_b[2];
        o_dec.count    = (v_n > 3'(MaxOut)) ? 2'(MaxOut) : v_n[1:0];
        o_dec.mode     = v_mode;
        o_dec.held     = v_held;
    end

endmodule

>>> hw/rtl/link_target_unescape.sv
// Top level of the link target unescaper: escape state and result buffer.
//
// Streaming percent and backslash unescaper for a link target. Each accepted
// byte is decoded in the cycle it is taken and yields zero to three output
// words, which are buffered and delivered one per cycle while i_out_ready is
// high. A byte is taken whenever the buffer is empty or is handing out its
// final word, so ordinary text moves at one byte per clock while i_out_ready
// is high; a byte that yields two or three words (a malformed escape or an
// end-of-target flush) holds the input while the buffer drains. o_in_ready
// depends on i_out_ready in the same cycle. o_run_end marks the last word
// caused by an input byte, and o_message_end the final word of the target.
module link_target_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_message_end
);
    import ltu_pkg::*;

    `include "link_target_unescape_defines.svh"

    t_mode           r_mode, n_mode;
    logic [7:0]      r_held, n_held;
    logic [2:0][7:0] r_bytes, n_bytes;
    logic [1:0]      r_rem, n_rem;
    logic            r_last, n_last;
    t_dec            dec;
    logic            acc;
    logic            take;

    ltu_decode u_decode (
        .i_mode (r_mode),
        .i_held (r_held),
        .i_byte (i_in_byte),
        .i_last (i_last_byte),
        .o_dec  (dec)
    );

    assign o_out_valid   = (r_rem != 2'd0);
    assign take          = o_out_valid && i_out_ready;
    assign o_in_ready    = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_out_ready);
    assign acc           = i_in_valid && o_in_ready;
    assign o_out_byte    = r_bytes[0];
    assign o_run_end     = (r_rem == 2'd1);
    assign o_message_end = (r_rem == 2'd1) && r_last;

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_bytes = r_bytes;
        n_rem   = r_rem;
        n_last  = r_last;
        if (acc) begin
            n_mode  = dec.mode;
            n_held  = dec.held;
            n_bytes = dec.bytes;
            n_rem   = dec.count;
            n_last  = i_last_byte;
        end else if (take) begin
            n_bytes[0] = r_bytes[1];
            n_bytes[1] = r_bytes[2];
            n_rem      = r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_held <= 8'h00;
            r_rem  <= 2'd0;
        end else begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_last  <= n_last;
    end

    `LTU_ASSERT(a_last_gives_word, i_clk, i_rst_n, (acc && i_last_byte) |=> o_out_valid)
    `LTU_ASSERT(a_last_clears_mode, i_clk, i_rst_n, (acc && i_last_byte) |=> (r_mode == MODE_PLAIN))
    `LTU_ASSERT(a_hold_only_in_escape, i_clk, i_rst_n,
        (acc && (dec.count == 2'd0)) |=> (r_mode != MODE_PLAIN))
    `LTU_ASSERT_ALWAYS(a_msg_end_is_run_end, i_clk, o_message_end |-> (o_run_end && o_out_valid))

endmodule
